### hw/rtl/sdcl_pkg.sv
// Shared types and constants for the SD command line host.
// Used by every module of the block; depends on nothing.
package sdcl_pkg;

    localparam int FRAME_BITS = 48;
    localparam int HEAD_BITS  = 40;
    localparam int CRC_BITS   = 7;
    localparam int RESP_BITS  = 47;
    localparam int RESP_OUT_W = RESP_BITS - 8;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);
    localparam int TIMEOUT_W  = 16;
    localparam int TRAIL_W    = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CRC_BITS-1:0]  CRC_POLY       = 7'h09;
    localparam logic [7:0]           R5_ERR_MASK    = 8'hCB;
    localparam logic [1:0]           CMD_PREFIX     = 2'b01;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd5000;
    localparam logic [TRAIL_W-1:0]   TRAIL_RESET    = 4'd8;

    // Register indexes of the configuration port.
    localparam logic CFG_IDX_TIMEOUT = 1'b0;
    localparam logic CFG_IDX_TRAIL   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_WAIT,
        PH_RECV,
        PH_TRAIL
    } phase_t;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic        line_sample;
    } item_t;

    typedef struct packed {
        logic                  line_out;
        logic                  line_drive;
        logic                  busy_res;
        logic                  done_res;
        logic                  status;
        logic [RESP_OUT_W-1:0] response;
        logic [7:0]            r5_data;
        logic                  r5_error;
    } result_t;

endpackage

### hw/rtl/sdcl_in_stage.sv
// Input register of the SD command line host.
// Holds one accepted item until the engine steps on it; uses sdcl_pkg.
module sdcl_in_stage
    import sdcl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t item,
    input  logic  advance,
    output logic  step,
    output item_t item_q
);

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;

    assign in_stall = in_valid_reg && !advance;
    assign step     = in_valid_reg && advance;
    assign item_q   = item_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item;
        end
    end

endmodule

### hw/rtl/sdcl_engine.sv
// Command frame sequencer, response receiver and configuration registers.
// Advances one bus clock per step and forms that tick's result; uses sdcl_pkg.
module sdcl_engine
    import sdcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  step,
    input  item_t                 item,
    output result_t               res
);

    phase_t                phase_reg, phase_next;
    logic [HEAD_BITS-1:0]  frame_reg, frame_next;
    logic [CRC_BITS-1:0]   crc_reg, crc_next;
    logic [BIT_CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [TIMEOUT_W-1:0]  wait_count_reg, wait_count_next;
    logic [RESP_BITS-1:0]  rx_reg, rx_next;
    logic [TRAIL_W-1:0]    trail_reg, trail_next;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [TRAIL_W-1:0]    trailing_reg;

    always_comb
    begin
        logic                 active;
        logic                 fin;
        logic                 fb;
        phase_t               ph;
        logic [HEAD_BITS-1:0] fr;
        logic [CRC_BITS-1:0]  crc;
        logic [BIT_CNT_W-1:0] bc;
        logic [TIMEOUT_W-1:0] wc;
        logic [TIMEOUT_W-1:0] lim;
        logic [RESP_BITS-1:0] rx;
        logic [TRAIL_W-1:0]   tc;

        res          = '0;
        res.line_out = 1'b1;
        active       = 1'b1;
        fin          = 1'b0;
        fb           = 1'b0;
        ph           = phase_reg;
        fr           = frame_reg;
        crc          = crc_reg;
        bc           = bit_count_reg;
        wc           = wait_count_reg;
        lim          = timeout_reg;
        rx           = rx_reg;
        tc           = trail_reg;
        wait_count_next = wait_count_reg;
        trail_next      = trail_reg;
        rx_next         = rx_reg;

        // A start item loads the frame head and already drives its first bit.
        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd)
            begin
                ph  = PH_SEND;
                fr  = {CMD_PREFIX, item.cmd_index, item.argument};
                crc = '0;
                bc  = BIT_CNT_W'(FRAME_BITS);
            end
            else
            begin
                active = 1'b0;
            end
        end

        if (active)
        begin
            res.busy_res = 1'b1;
            unique case (ph)
                PH_SEND:
                begin
                    res.line_drive = 1'b1;
                    // The CRC is built as the head goes out, then shifted out itself, then the end bit.
                    if (bc > BIT_CNT_W'(CRC_BITS + 1))
                    begin
                        res.line_out = fr[HEAD_BITS-1];
                        fb  = fr[HEAD_BITS-1] ^ crc[CRC_BITS-1];
                        crc = {crc[CRC_BITS-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
                        fr  = {fr[HEAD_BITS-2:0], 1'b0};
                    end
                    else if (bc > BIT_CNT_W'(1))
                    begin
                        res.line_out = crc[CRC_BITS-1];
                        crc = {crc[CRC_BITS-2:0], 1'b0};
                    end
                    else
                    begin
                        res.line_out = 1'b1;
                    end
                    bc = bc - BIT_CNT_W'(1);
                    if (bc == '0)
                    begin
                        ph = PH_WAIT;
                        wait_count_next = '0;
                    end
                end
                PH_WAIT:
                begin
                    if (!item.line_sample)
                    begin
                        ph      = PH_RECV;
                        bc      = '0;
                        rx_next = '0;
                    end
                    else
                    begin
                        if (timeout_reg == '0)
                        begin
                            lim = TIMEOUT_W'(1);
                        end
                        if (wc != '1)
                        begin
                            wc = wc + TIMEOUT_W'(1);
                        end
                        wait_count_next = wc;
                        if (wc >= lim)
                        begin
                            res.done_res = 1'b1;
                            res.status   = 1'b1;
                            ph           = PH_IDLE;
                        end
                    end
                end
                PH_RECV:
                begin
                    rx      = {rx[RESP_BITS-2:0], item.line_sample};
                    rx_next = rx;
                    bc      = bc + BIT_CNT_W'(1);
                    if (bc >= BIT_CNT_W'(RESP_BITS))
                    begin
                        if (trailing_reg == '0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            trail_next = trailing_reg;
                            ph         = PH_TRAIL;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    if (tc != '0)
                    begin
                        tc = tc - TRAIL_W'(1);
                    end
                    trail_next = tc;
                    if (tc == '0)
                    begin
                        fin = 1'b1;
                    end
                end
                default:
                begin
                    ph           = PH_IDLE;
                    res.busy_res = 1'b0;
                end
            endcase
        end

        if (fin)
        begin
            res.done_res = 1'b1;
            res.status   = 1'b0;
            res.response = rx[RESP_BITS-1:8];
            res.r5_data  = rx[15:8];
            res.r5_error = |(rx[23:16] & R5_ERR_MASK);
            ph           = PH_IDLE;
        end

        phase_next     = ph;
        frame_next     = fr;
        crc_next       = crc;
        bit_count_next = bc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            wait_count_reg <= '0;
            trail_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            wait_count_reg <= wait_count_next;
            trail_reg      <= trail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            frame_reg <= frame_next;
            crc_reg   <= crc_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            trailing_reg <= TRAIL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_TIMEOUT: timeout_reg  <= cfg_data;
                CFG_IDX_TRAIL:   trailing_reg <= cfg_data[TRAIL_W-1:0];
                default:         timeout_reg  <= timeout_reg;
            endcase
        end
    end

endmodule

### hw/rtl/sdcl_out_stage.sv
// Result register of the SD command line host.
// Holds one tick's result until the consumer takes it; uses sdcl_pkg.
module sdcl_out_stage
    import sdcl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  result_t res,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t res_q
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    // The register may be refilled in the cycle its contents are transferred.
    assign advance   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

endmodule

### hw/rtl/sd_command_line_host.sv
// Top level of the SD command line host: input register, engine, result register.
// Depends on sdcl_pkg, sdcl_in_stage, sdcl_engine and sdcl_out_stage.

// Each input transfer is one SD bus clock and yields exactly one result transfer.
// A new item is taken every cycle unless a held result stalls the input. An item's
// result passes through the input register and then the result register, where it
// is held until it is transferred. The rate is set by the single-step engine between
// them. A start item begins a 48-bit command frame, then the line is sampled for
// the response start bit for up to response_timeout ticks, 47 response bits are
// shifted in, and trailing_clocks idle ticks follow before done. Configuration
// writes are taken on any cycle with cfg_write high and are meant to be issued
// while idle.
module sd_command_line_host
    import sdcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [5:0]            cmd_index,
    input  logic [31:0]           argument,
    input  logic                  line_sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  line_out,
    output logic                  line_drive,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  status,
    output logic [RESP_OUT_W-1:0] response,
    output logic [7:0]            r5_data,
    output logic                  r5_error
);

    item_t   item_in;
    item_t   item_q;
    result_t res;
    result_t res_q;
    logic    step;
    logic    advance;

    assign item_in.cmd         = cmd;
    assign item_in.cmd_index   = cmd_index;
    assign item_in.argument    = argument;
    assign item_in.line_sample = line_sample;

    sdcl_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item     (item_in),
        .advance  (advance),
        .step     (step),
        .item_q   (item_q)
    );

    sdcl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item_q),
        .res       (res)
    );

    sdcl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_q     (res_q)
    );

    assign line_out   = res_q.line_out;
    assign line_drive = res_q.line_drive;
    assign busy_res   = res_q.busy_res;
    assign done_res   = res_q.done_res;
    assign status     = res_q.status;
    assign response   = res_q.response;
    assign r5_data    = res_q.r5_data;
    assign r5_error   = res_q.r5_error;

`ifndef SYNTH
    // The input side only holds off while a finished result is being held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register is free");

    // The host drives the line only inside a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_drive) |-> (busy_res && !done_res))
        else $error("line driven outside the command frame");

    // A timeout status is only reported on a finishing tick with no response data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (done_res && busy_res && response == '0))
        else $error("status set without a finishing tick");
`endif

endmodule

### tb/sv/testbench.sv
// Testbench for the SD command line host: drives bus ticks and checks every result
// against a cycle-free model of the command frame, response wait, receive and trail.
// Depends on sdcl_pkg and sd_command_line_host.
module testbench;
    import sdcl_pkg::*;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 50;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic                  cfg_index   = CFG_IDX_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  cmd         = 1'b0;
    logic [5:0]            cmd_index   = '0;
    logic [31:0]           argument    = '0;
    logic                  line_sample = 1'b1;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  line_out;
    logic                  line_drive;
    logic                  busy_res;
    logic                  done_res;
    logic                  status;
    logic [RESP_OUT_W-1:0] response;
    logic [7:0]            r5_data;
    logic                  r5_error;

    // Model copy of the registers and the engine state.
    logic [TIMEOUT_W-1:0]  cfg_timeout = TIMEOUT_RESET;
    logic [TRAIL_W-1:0]    cfg_trail   = TRAIL_RESET;
    phase_t                ph          = PH_IDLE;
    logic [FRAME_BITS-1:0] frame_bits  = '0;
    logic [5:0]            bit_cnt     = '0;
    logic [TIMEOUT_W-1:0]  wait_cnt    = '0;
    logic [RESP_BITS-1:0]  rx_bits     = '0;
    logic [TRAIL_W-1:0]    trail_left  = '0;

    result_t expected_ticks[$];
    result_t want;
    result_t got;
    bit      steady       = 1'b0;
    int      holds_asked  = 0;
    int      holds_served = 0;
    int      hold_left    = 0;
    int      idle_cycles  = 0;
    int      mismatches   = 0;
    int      results_seen = 0;

    sd_command_line_host i_dut (.*);

    always #2 clk = ~clk;

    function automatic logic [CRC_BITS-1:0] crc7_of_head(input logic [HEAD_BITS-1:0] head);
        logic [CRC_BITS-1:0] crc;
        logic                fb;
        int                  i;
        crc = '0;
        for (i = HEAD_BITS - 1; i >= 0; i--)
        begin
            fb  = head[i] ^ crc[CRC_BITS-1];
            crc = {crc[CRC_BITS-2:0], 1'b0};
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    function automatic void fill_response(inout result_t r);
        r.done_res = 1'b1;
        r.status   = 1'b0;
        r.response = rx_bits[RESP_BITS-1:8];
        r.r5_data  = rx_bits[15:8];
        r.r5_error = |(rx_bits[23:16] & R5_ERR_MASK);
        ph         = PH_IDLE;
    endfunction

    // Advances the model by one bus tick and returns what the block shows on it.
    function automatic result_t host_tick(input logic st, input logic [5:0] idx,
                                          input logic [31:0] arg, input logic smp);
        result_t                r;
        logic [HEAD_BITS-1:0]   head;
        logic [TIMEOUT_W-1:0]   lim;
        r = '0;
        r.line_out = 1'b1;
        if (ph == PH_IDLE)
        begin
            if (!st)
                return r;
            head       = {CMD_PREFIX, idx, arg};
            frame_bits = {head, crc7_of_head(head), 1'b1};
            bit_cnt    = 6'(FRAME_BITS);
            ph         = PH_SEND;
        end
        r.busy_res = 1'b1;
        case (ph)
            PH_SEND:
            begin
                r.line_out   = frame_bits[FRAME_BITS-1];
                r.line_drive = 1'b1;
                frame_bits   = {frame_bits[FRAME_BITS-2:0], 1'b0};
                bit_cnt      = bit_cnt - 6'd1;
                if (bit_cnt == 0)
                begin
                    ph       = PH_WAIT;
                    wait_cnt = '0;
                end
            end
            PH_WAIT:
            begin
                if (!smp)
                begin
                    ph      = PH_RECV;
                    bit_cnt = '0;
                    rx_bits = '0;
                end
                else
                begin
                    // A zero limit still takes one sample.
                    lim = (cfg_timeout == 0) ? 16'd1 : cfg_timeout;
                    if (wait_cnt != 16'hFFFF)
                        wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= lim)
                    begin
                        r.done_res = 1'b1;
                        r.status   = 1'b1;
                        ph         = PH_IDLE;
                    end
                end
            end
            PH_RECV:
            begin
                rx_bits = {rx_bits[RESP_BITS-2:0], smp};
                bit_cnt = bit_cnt + 6'd1;
                if (bit_cnt >= 6'(RESP_BITS))
                begin
                    if (cfg_trail == 0)
                        fill_response(r);
                    else
                    begin
                        trail_left = cfg_trail;
                        ph         = PH_TRAIL;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (trail_left != 0)
                    trail_left = trail_left - 4'd1;
                if (trail_left == 0)
                    fill_response(r);
            end
            default:
            begin
                ph         = PH_IDLE;
                r.busy_res = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic logic random_bit();
        return $urandom_range(1) != 0;
    endfunction

    function automatic logic [31:0] pick_argument();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RESP_BITS-1:0] random_response();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[RESP_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     what, results_seen, seen, wanted);
    endtask

    // One bus tick per transfer; the model is stepped when the transfer happens.
    task automatic send_tick(input logic st, input logic [5:0] idx,
                             input logic [31:0] arg, input logic smp);
        in_valid    <= 1'b1;
        cmd         <= st;
        cmd_index   <= idx;
        argument    <= arg;
        line_sample <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_ticks.push_back(host_tick(st, idx, arg, smp));
        if (!steady && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Waits on the clock before it first checks the queue, so back-to-back calls drive at distinct times.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_ticks.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        pause_until_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_IDX_TIMEOUT)
            cfg_timeout = value;
        else
            cfg_trail = value[TRAIL_W-1:0];
    endtask

    // Start items sent while the frame goes out must be ignored.
    task automatic begin_command(input logic [5:0] idx, input logic [31:0] arg);
        send_tick(1'b1, idx, arg, random_bit());
        while (ph == PH_SEND)
            send_tick(random_bit(), 6'($urandom), pick_argument(), random_bit());
    endtask

    task automatic hold_line_high(input int n);
        repeat (n)
            if (ph == PH_WAIT)
                send_tick(random_bit(), 6'($urandom), pick_argument(), 1'b1);
    endtask

    task automatic respond(input logic [RESP_BITS-1:0] resp, input int count);
        int i;
        if (ph == PH_WAIT)
            send_tick(random_bit(), 6'($urandom), pick_argument(), 1'b0);
        for (i = 0; i < count; i++)
            if (ph == PH_RECV)
                send_tick(random_bit(), 6'($urandom), pick_argument(),
                          resp[RESP_BITS - 1 - bit_cnt]);
    endtask

    task automatic finish_command();
        while (ph != PH_IDLE)
            send_tick(random_bit(), 6'($urandom), pick_argument(), random_bit());
    endtask

    task automatic run_command(input logic [5:0] idx, input logic [31:0] arg,
                               input int waits, input logic [RESP_BITS-1:0] resp);
        begin_command(idx, arg);
        hold_line_high(waits);
        respond(resp, RESP_BITS);
        finish_command();
    endtask

    // Mostly complete commands with random content; a tenth of the ticks are noise.
    task automatic run_random_traffic(input int count, input int answer_pct);
        int   counted;
        logic st;
        logic smp;
        counted = 0;
        while (counted < count)
        begin
            if ($urandom_range(99) < 10)
            begin
                st  = random_bit();
                smp = random_bit();
            end
            else
            begin
                st  = (ph == PH_IDLE) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 10);
                smp = (ph == PH_WAIT) ? !($urandom_range(99) < answer_pct) : random_bit();
            end
            if (ph != PH_IDLE || st)
                counted++;
            send_tick(st, 6'($urandom), pick_argument(), smp);
        end
        finish_command();
    endtask

    task automatic test_reset_defaults();
        repeat (3) send_tick(1'b0, 6'd63, 32'hFFFF_FFFF, 1'b0);
        run_command(6'd0, 32'h0, 0, '0);
        run_command(6'd63, 32'hFFFF_FFFF, 3, '1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_IDX_TIMEOUT, 16'hFFFF);
        write_reg(CFG_IDX_TRAIL, 16'd0);
        run_command(6'd52, pick_argument(), 2, random_response());
        write_reg(CFG_IDX_TIMEOUT, 16'd0);
        write_reg(CFG_IDX_TRAIL, 16'd15);
        run_command(6'd17, pick_argument(), 1, random_response());
        run_command(6'd42, pick_argument(), 0, random_response());
    endtask

    task automatic test_config_midway();
        write_reg(CFG_IDX_TIMEOUT, 16'd10);
        write_reg(CFG_IDX_TRAIL, 16'd2);
        begin_command(6'd5, pick_argument());
        hold_line_high(5);
        // The wait count is already past the new limit, so the next high sample ends it.
        write_reg(CFG_IDX_TIMEOUT, 16'd3);
        hold_line_high(1);
        finish_command();
        begin_command(6'd52, pick_argument());
        respond(random_response(), 20);
        // Upper data bits are dropped, so reception ends with no trailing clocks.
        write_reg(CFG_IDX_TRAIL, 16'hFFF0);
        respond(random_response(), RESP_BITS);
        finish_command();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_IDX_TIMEOUT, 16'd6);
        write_reg(CFG_IDX_TRAIL, 16'd4);
        holds_asked++;
        run_command(6'($urandom), pick_argument(), 3, random_response());
        pause_until_drained();
    endtask

    task automatic test_random_traffic();
        write_reg(CFG_IDX_TIMEOUT, 16'd4);
        write_reg(CFG_IDX_TRAIL, 16'd0);
        run_random_traffic(110, 30);
        write_reg(CFG_IDX_TIMEOUT, 16'd1);
        write_reg(CFG_IDX_TRAIL, 16'd15);
        run_random_traffic(110, 60);
        steady = 1'b1;
        write_reg(CFG_IDX_TIMEOUT, 16'd12);
        write_reg(CFG_IDX_TRAIL, 16'd1);
        run_random_traffic(120, 20);
        steady = 1'b0;
        write_reg(CFG_IDX_TIMEOUT, 16'hFFFF);
        write_reg(CFG_IDX_TRAIL, 16'd8);
        run_random_traffic(90, 40);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            hold_left    <= HOLD_OFF_CYCLES;
            out_stall    <= 1'b1;
        end
        else
            out_stall <= !steady && ($urandom_range(99) < 20);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_ticks.size() == 0)
                report_mismatch("unexpected transfer", 64'd1, 64'd0);
            else
            begin
                want = expected_ticks.pop_front();
                got  = {line_out, line_drive, busy_res, done_res, status,
                        response, r5_data, r5_error};
                if (got.line_out !== want.line_out)
                    report_mismatch("line_out", 64'(got.line_out), 64'(want.line_out));
                if (got.line_drive !== want.line_drive)
                    report_mismatch("line_drive", 64'(got.line_drive), 64'(want.line_drive));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 64'(got.busy_res), 64'(want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", 64'(got.done_res), 64'(want.done_res));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.response !== want.response)
                    report_mismatch("response", 64'(got.response), 64'(want.response));
                if (got.r5_data !== want.r5_data)
                    report_mismatch("r5_data", 64'(got.r5_data), 64'(want.r5_data));
                if (got.r5_error !== want.r5_error)
                    report_mismatch("r5_error", 64'(got.r5_error), 64'(want.r5_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_config_midway();
        test_backpressure();
        test_random_traffic();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sdcl_pkg.sv
hw/rtl/sdcl_in_stage.sv
hw/rtl/sdcl_engine.sv
hw/rtl/sdcl_out_stage.sv
hw/rtl/sd_command_line_host.sv
tb/sv/testbench.sv
